FILE: rtl/core/ustd_pkg.sv
// Shared types, widths and constant divisors for the Unix-seconds to UTC date converter.
// Used by every module of the converter; depends on nothing.
package ustd_pkg;

    // Field widths.
    localparam int SECS_W  = 36;
    localparam int YEAR_W  = 13;
    localparam int MONTH_W = 4;
    localparam int MDAY_W  = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Internal widths.
    localparam int DAYS_W  = 20;    // whole days, at most 795364
    localparam int SOD_W   = 17;    // second of day
    localparam int SOH_W   = 12;    // second of hour
    localparam int C400_W  = 3;     // 400-year cycles, at most 5
    localparam int D400_W  = 18;    // day inside a 400-year cycle
    localparam int C4_W    = 7;     // 4-year cycles inside a 400-year cycle
    localparam int D4_W    = 11;    // day inside a 4-year cycle
    localparam int DY_W    = 9;     // day inside a 366-day slot

    // Seconds to days: (secs >> 7) / 675, reciprocal floor(2^29 / 675).
    localparam int DAY_SHIFT  = 7;
    localparam int DAY_HI_W   = SECS_W - DAY_SHIFT;
    localparam int DAY_DIV    = 675;
    localparam int DAY_RECIP  = 795364;
    localparam int DAY_K      = 29;

    // Second of day to hour, reciprocal floor(2^17 / 3600).
    localparam int HOUR_DIV   = 3600;
    localparam int HOUR_RECIP = 36;
    localparam int HOUR_K     = 17;

    // Second of hour to minute, reciprocal floor(2^12 / 60).
    localparam int MIN_DIV    = 60;
    localparam int MIN_RECIP  = 68;
    localparam int MIN_K      = 12;

    // Days to 400-year cycles, reciprocal floor(2^20 / 146097).
    localparam int C400_DIV   = 146097;
    localparam int C400_RECIP = 7;
    localparam int C400_K     = 20;

    // Day of 400-year cycle to 4-year cycles, reciprocal floor(2^18 / 1461).
    localparam int C4_DIV     = 1461;
    localparam int C4_RECIP   = 179;
    localparam int C4_K       = 18;

    // Points where a skipped century leap day is put back.
    localparam int CENT_SKIP0 = 32 * 1461 + 789;
    localparam int CENT_SKIP1 = 57 * 1461 + 789;
    localparam int CENT_SKIP2 = 82 * 1461 + 789;

    // Points where the missing February 29th of a common year is put back.
    localparam int FEB_SKIP0  = 59;
    localparam int FEB_SKIP1  = 425;
    localparam int FEB_SKIP2  = 1157;

    localparam int SLOT_LEN   = 366;
    localparam int BASE_YEAR  = 1970;
    localparam int CYCLE_YEARS = 400;

    // Pipeline depths.
    localparam int DAY_LAT  = 2;
    localparam int CLK_LAT  = 4;
    localparam int DATE_LAT = 8;
    localparam int PIPE_LAT = DAY_LAT + DATE_LAT;
    localparam int CLK_PAD  = DATE_LAT - CLK_LAT;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } t_clock;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [MDAY_W-1:0]  day_of_month;
    } t_date;

    // First day of each month inside a leap year, counted from 0.
    function automatic logic [DY_W-1:0] month_start(input logic [MONTH_W-1:0] idx);
        logic [DY_W-1:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd60;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd121;
            4'd5:    v = 9'd152;
            4'd6:    v = 9'd182;
            4'd7:    v = 9'd213;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd274;
            4'd10:   v = 9'd305;
            4'd11:   v = 9'd335;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/ustd_day_split.sv
// Two-stage split of a seconds count into whole days and the second of the day.
// Depends on ustd_pkg for widths and the reciprocal constants.
module ustd_day_split
    import ustd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SECS_W-1:0] i_secs,
    output logic [DAYS_W-1:0] o_days,
    output logic [SOD_W-1:0]  o_sod
);

    localparam int PROD_W = DAY_HI_W + DAYS_W;
    localparam int QM_W   = DAYS_W + 10;
    localparam int REM_W  = 11;

    logic [DAY_HI_W-1:0]  w_hi;
    logic [PROD_W-1:0]    w_prod;
    logic [DAYS_W-1:0]    n_q;
    logic [DAYS_W-1:0]    r_q;
    logic [DAY_HI_W-1:0]  r_hi;
    logic [DAY_SHIFT-1:0] r_lo;

    logic [QM_W-1:0]      w_qm;
    logic [DAY_HI_W-1:0]  w_diff;
    logic [REM_W-1:0]     w_rem;
    logic [DAYS_W-1:0]    n_days;
    logic [SOD_W-1:0]     n_sod;
    logic [DAYS_W-1:0]    r_days;
    logic [SOD_W-1:0]     r_sod;

    // Dividing by 86400 is a shift by 7 and a division by 675.
    assign w_hi   = i_secs[SECS_W-1:DAY_SHIFT];
    assign w_prod = PROD_W'(w_hi) * PROD_W'(DAY_RECIP);
    assign n_q    = w_prod[DAY_K +: DAYS_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q  <= n_q;
            r_hi <= w_hi;
            r_lo <= i_secs[DAY_SHIFT-1:0];
        end
    end

    // The estimate is exact or one short; one compare fixes it.
    assign w_qm   = QM_W'(r_q) * QM_W'(DAY_DIV);
    assign w_diff = r_hi - w_qm[DAY_HI_W-1:0];
    assign w_rem  = w_diff[REM_W-1:0];

    always_comb begin
        if (w_rem >= REM_W'(DAY_DIV)) begin
            n_days = r_q + DAYS_W'(1);
            n_sod  = {10'(w_rem - REM_W'(DAY_DIV)), r_lo};
        end else begin
            n_days = r_q;
            n_sod  = {w_rem[9:0], r_lo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_days <= n_days;
            r_sod  <= n_sod;
        end
    end

    assign o_days = r_days;
    assign o_sod  = r_sod;

endmodule

FILE: rtl/core/ustd_clock_split.sv
// Four-stage split of the second of the day into hour, minute and second.
// Depends on ustd_pkg for widths, divisors and the t_clock type.
module ustd_clock_split
    import ustd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [SOD_W-1:0] i_sod,
    output t_clock           o_clock
);

    logic [22:0]         w_hprod;
    logic [SOD_W-1:0]    r_sod;
    logic [HOUR_W-1:0]   r_hour_e;

    logic [SOD_W-1:0]    w_hmul;
    logic [SOD_W-1:0]    w_hdiff;
    logic [HOUR_W-1:0]   n_hour;
    logic [SOH_W-1:0]    n_soh;
    logic [HOUR_W-1:0]   r_hour;
    logic [SOH_W-1:0]    r_soh;

    logic [17:0]         w_mprod;
    logic [HOUR_W-1:0]   r_hour2;
    logic [SOH_W-1:0]    r_soh2;
    logic [MIN_W-1:0]    r_min_e;

    logic [SOH_W-1:0]    w_mmul;
    logic [SOH_W-1:0]    w_mdiff;
    logic [MIN_W-1:0]    n_min;
    logic [SEC_W-1:0]    n_sec;
    t_clock              r_clock;

    assign w_hprod = 23'(i_sod) * 23'(HOUR_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sod    <= i_sod;
            r_hour_e <= w_hprod[HOUR_K +: HOUR_W];
        end
    end

    assign w_hmul  = SOD_W'(r_hour_e) * SOD_W'(HOUR_DIV);
    assign w_hdiff = r_sod - w_hmul;

    always_comb begin
        if (w_hdiff >= SOD_W'(HOUR_DIV)) begin
            n_hour = r_hour_e + HOUR_W'(1);
            n_soh  = SOH_W'(w_hdiff - SOD_W'(HOUR_DIV));
        end else begin
            n_hour = r_hour_e;
            n_soh  = w_hdiff[SOH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hour <= n_hour;
            r_soh  <= n_soh;
        end
    end

    assign w_mprod = 18'(r_soh) * 18'(MIN_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hour2 <= r_hour;
            r_soh2  <= r_soh;
            r_min_e <= w_mprod[MIN_K +: MIN_W];
        end
    end

    assign w_mmul  = SOH_W'(r_min_e) * SOH_W'(MIN_DIV);
    assign w_mdiff = r_soh2 - w_mmul;

    always_comb begin
        if (w_mdiff >= SOH_W'(MIN_DIV)) begin
            n_min = r_min_e + MIN_W'(1);
            n_sec = SEC_W'(w_mdiff - SOH_W'(MIN_DIV));
        end else begin
            n_min = r_min_e;
            n_sec = w_mdiff[SEC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_clock.hour   <= r_hour2;
            r_clock.minute <= n_min;
            r_clock.second <= n_sec;
        end
    end

    assign o_clock = r_clock;

endmodule

FILE: rtl/core/ustd_date_split.sv
// Eight-stage conversion of a day count since 1970 into year, month and day of month.
// Depends on ustd_pkg for the cycle constants, the month table and the t_date type.
module ustd_date_split
    import ustd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DAYS_W-1:0] i_days,
    output t_date             o_date
);

    // Stage 1: estimate of the 400-year cycle.
    logic [22:0]          w_c400_prod;
    logic [DAYS_W-1:0]    r1_days;
    logic [C400_W-1:0]    r1_c400;

    // Stage 2: corrected cycle and day inside it.
    logic [DAYS_W-1:0]    w_c400_mul;
    logic [DAYS_W-1:0]    w_c400_diff;
    logic [C400_W-1:0]    n_c400;
    logic [D400_W-1:0]    n_d400;
    logic [C400_W-1:0]    r2_c400;
    logic [D400_W-1:0]    r2_d400;

    // Stage 3: skipped century leap days put back.
    logic [D400_W-1:0]    w_cent0;
    logic [D400_W-1:0]    w_cent1;
    logic [D400_W-1:0]    n_d400a;
    logic [C400_W-1:0]    r3_c400;
    logic [D400_W-1:0]    r3_d400;

    // Stage 4: estimate of the 4-year cycle.
    logic [24:0]          w_c4_prod;
    logic [C400_W-1:0]    r4_c400;
    logic [D400_W-1:0]    r4_d400;
    logic [C4_W-1:0]      r4_c4;

    // Stage 5: corrected 4-year cycle and day inside it.
    logic [D400_W-1:0]    w_c4_mul;
    logic [D400_W-1:0]    w_c4_diff;
    logic [C4_W-1:0]      n_c4;
    logic [D4_W-1:0]      n_d4;
    logic [C400_W-1:0]    r5_c400;
    logic [C4_W-1:0]      r5_c4;
    logic [D4_W-1:0]      r5_d4;

    // Stage 6: missing February 29ths put back.
    logic [D4_W-1:0]      w_feb0;
    logic [D4_W-1:0]      w_feb1;
    logic [D4_W-1:0]      n_d4a;
    logic [C400_W-1:0]    r6_c400;
    logic [C4_W-1:0]      r6_c4;
    logic [D4_W-1:0]      r6_d4;

    // Stage 7: year and day of year.
    logic [1:0]           w_slot;
    logic [D4_W-1:0]      w_slot_base;
    logic [YEAR_W-1:0]    n_year;
    logic [DY_W-1:0]      n_dy;
    logic [YEAR_W-1:0]    r7_year;
    logic [DY_W-1:0]      r7_dy;

    // Stage 8: month and day of month.
    logic [MONTH_W-1:0]   w_midx;
    logic [DY_W-1:0]      w_mday;
    t_date                r8_date;

    assign w_c400_prod = 23'(i_days) * 23'(C400_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_days <= i_days;
            r1_c400 <= w_c400_prod[C400_K +: C400_W];
        end
    end

    assign w_c400_mul  = DAYS_W'(r1_c400) * DAYS_W'(C400_DIV);
    assign w_c400_diff = r1_days - w_c400_mul;

    always_comb begin
        if (w_c400_diff >= DAYS_W'(C400_DIV)) begin
            n_c400 = r1_c400 + C400_W'(1);
            n_d400 = D400_W'(w_c400_diff - DAYS_W'(C400_DIV));
        end else begin
            n_c400 = r1_c400;
            n_d400 = w_c400_diff[D400_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_c400 <= n_c400;
            r2_d400 <= n_d400;
        end
    end

    // Each insertion moves the day, so the next threshold sees the moved value.
    assign w_cent0 = r2_d400 + D400_W'(r2_d400 >= D400_W'(CENT_SKIP0));
    assign w_cent1 = w_cent0 + D400_W'(w_cent0 >= D400_W'(CENT_SKIP1));
    assign n_d400a = w_cent1 + D400_W'(w_cent1 >= D400_W'(CENT_SKIP2));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_c400 <= r2_c400;
            r3_d400 <= n_d400a;
        end
    end

    assign w_c4_prod = 25'(r3_d400) * 25'(C4_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_c400 <= r3_c400;
            r4_d400 <= r3_d400;
            r4_c4   <= w_c4_prod[C4_K +: C4_W];
        end
    end

    assign w_c4_mul  = D400_W'(r4_c4) * D400_W'(C4_DIV);
    assign w_c4_diff = r4_d400 - w_c4_mul;

    always_comb begin
        if (w_c4_diff >= D400_W'(C4_DIV)) begin
            n_c4 = r4_c4 + C4_W'(1);
            n_d4 = D4_W'(w_c4_diff - D400_W'(C4_DIV));
        end else begin
            n_c4 = r4_c4;
            n_d4 = w_c4_diff[D4_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_c400 <= r4_c400;
            r5_c4   <= n_c4;
            r5_d4   <= n_d4;
        end
    end

    assign w_feb0 = r5_d4 + D4_W'(r5_d4 >= D4_W'(FEB_SKIP0));
    assign w_feb1 = w_feb0 + D4_W'(w_feb0 >= D4_W'(FEB_SKIP1));
    assign n_d4a  = w_feb1 + D4_W'(w_feb1 >= D4_W'(FEB_SKIP2));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_c400 <= r5_c400;
            r6_c4   <= r5_c4;
            r6_d4   <= n_d4a;
        end
    end

    always_comb begin
        if (r6_d4 >= D4_W'(3 * SLOT_LEN)) begin
            w_slot      = 2'd3;
            w_slot_base = D4_W'(3 * SLOT_LEN);
        end else if (r6_d4 >= D4_W'(2 * SLOT_LEN)) begin
            w_slot      = 2'd2;
            w_slot_base = D4_W'(2 * SLOT_LEN);
        end else if (r6_d4 >= D4_W'(SLOT_LEN)) begin
            w_slot      = 2'd1;
            w_slot_base = D4_W'(SLOT_LEN);
        end else begin
            w_slot      = 2'd0;
            w_slot_base = '0;
        end
        n_dy   = DY_W'(r6_d4 - w_slot_base);
        n_year = YEAR_W'(BASE_YEAR) + YEAR_W'(w_slot) + YEAR_W'({r6_c4, 2'b00})
               + YEAR_W'(r6_c400) * YEAR_W'(CYCLE_YEARS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_year <= n_year;
            r7_dy   <= n_dy;
        end
    end

    // The month is the number of later month starts that the day has reached.
    always_comb begin
        w_midx = '0;
        for (int i = 1; i < 12; i++) begin
            if (r7_dy >= month_start(MONTH_W'(i))) begin
                w_midx = w_midx + MONTH_W'(1);
            end
        end
        w_mday = r7_dy - month_start(w_midx) + DY_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_date.year         <= r7_year;
            r8_date.month        <= w_midx + MONTH_W'(1);
            r8_date.day_of_month <= w_mday[MDAY_W-1:0];
        end
    end

    assign o_date = r8_date;

endmodule

FILE: rtl/core/unix_seconds_to_utc_date_core.sv
// Top level of the Unix-seconds to UTC calendar date converter: stream ports and pipeline control.
// Depends on ustd_pkg, ustd_day_split, ustd_clock_split and ustd_date_split.
//
//  Channel   Direction  Carries                                   Width
//  s_axis    in         epoch_seconds                             40 (36 used)
//  m_axis    out        year, month, day_of_month, hour, min, sec 40 (39 used)
//
// Requests pass the day split and then the date split registers; a new request can enter each
// cycle while no result waits untaken on m_axis. The depth is set by the constant divisions,
// each an estimate stage with a multiplier followed by a correction stage.
// Reset clears only the valid bits of the pipeline. A result not taken on m_axis
// freezes the whole pipeline, and s_axis_tready drops until it is taken.
module unix_seconds_to_utc_date_core
    import ustd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // epoch_seconds[35:0], zero pad
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // year, month, day_of_month, hour,
                                                     // minute, second, zero pad
);

    logic                w_en;
    logic [PIPE_LAT-1:0] r_vld;
    logic [DAYS_W-1:0]   w_days;
    logic [SOD_W-1:0]    w_sod;
    t_clock              w_clock;
    t_clock              r_clk_dly [CLK_PAD];
    t_date               w_date;

    // The pipeline moves when the result register is empty or being taken.
    assign w_en            = !r_vld[PIPE_LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_s_axis_tvalid};
        end
    end

    ustd_day_split u_day_split (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_secs (i_s_axis_tdata[SECS_W-1:0]),
        .o_days (w_days),
        .o_sod  (w_sod)
    );

    ustd_clock_split u_clock_split (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_sod   (w_sod),
        .o_clock (w_clock)
    );

    ustd_date_split u_date_split (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_days (w_days),
        .o_date (w_date)
    );

    // The time of day is ready earlier than the date; hold it back to line up.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_clk_dly[0] <= w_clock;
            for (int i = 1; i < CLK_PAD; i++) begin
                r_clk_dly[i] <= r_clk_dly[i-1];
            end
        end
    end

    assign o_m_axis_tdata = {
        1'b0,
        r_clk_dly[CLK_PAD-1].second,
        r_clk_dly[CLK_PAD-1].minute,
        r_clk_dly[CLK_PAD-1].hour,
        w_date.day_of_month,
        w_date.month,
        w_date.year
    };

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_date.month >= MONTH_W'(1)) && (w_date.month <= MONTH_W'(12)))
        else $error("month out of range");

    a_mday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> w_date.day_of_month != '0)
        else $error("day of month is zero");

    a_clock_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_clk_dly[CLK_PAD-1].hour <= HOUR_W'(23))
                         && (r_clk_dly[CLK_PAD-1].minute <= MIN_W'(59))
                         && (r_clk_dly[CLK_PAD-1].second <= SEC_W'(59)))
        else $error("time of day out of range");

    a_year_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> w_date.year >= YEAR_W'(BASE_YEAR))
        else $error("year below epoch");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

FILE: tb/tb_unix_seconds_to_utc_date_core.sv
// Self-checking testbench for unix_seconds_to_utc_date_core: a table of directed timestamps,
// then random ones, checked against typed values or a calendar predictor held in the bench.
// Depends on ustd_pkg and the converter RTL.
module tb_unix_seconds_to_utc_date_core;
    import ustd_pkg::*;

    localparam int                WATCHDOG_LIMIT = 4000;
    localparam int                RANDOM_COUNT   = 1600;
    localparam int                QUIET_TAIL     = 200;
    localparam int                HOLD_CYCLES    = 250;
    localparam longint unsigned   SEC_PER_DAY    = 64'd86400;
    localparam longint unsigned   MAX_SECS       = 64'hF_FFFF_FFFF;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [MDAY_W-1:0]  mday;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_utc;

    typedef struct packed {
        logic [SECS_W-1:0] secs;
        logic [3:0]        pad;
        logic              typed;
        t_utc              want;
    } t_row;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;   // epoch_seconds, zero pad
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;         // year, month, day_of_month, hour,
                                                    // minute, second, zero pad

    int unsigned month_days [12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    t_utc pending_dates [$];
    int   n_errors   = 0;
    int   n_requests = 0;
    int   n_results  = 0;
    bit   sender_gaps   = 1'b1;
    bit   receiver_gaps = 1'b1;
    bit   quiet_tail    = 1'b0;
    bit   hold_req      = 1'b0;

    unix_seconds_to_utc_date_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Calendar date and time of day for a count of seconds since 1970.
    function automatic t_utc utc_of_seconds(input logic [SECS_W-1:0] secs);
        longint unsigned t;
        longint unsigned days;
        longint unsigned c400;
        longint unsigned d400;
        longint unsigned c4;
        longint unsigned d4;
        longint unsigned slot;
        longint unsigned dy;
        int unsigned     m;
        t_utc            r;
        t = secs;
        r.second = SEC_W'(t % 60);
        t = t / 60;
        r.minute = MIN_W'(t % 60);
        t = t / 60;
        r.hour = HOUR_W'(t % 24);
        days = t / 24;
        c400 = days / 146097;
        d400 = days % 146097;
        // Days are counted as if every fourth year were leap; put the skipped
        // century leap days back so that each 4-year group has 1461 days.
        if (d400 >= CENT_SKIP0) d400++;
        if (d400 >= CENT_SKIP1) d400++;
        if (d400 >= CENT_SKIP2) d400++;
        c4 = d400 / 1461;
        d4 = d400 % 1461;
        // Give each common year a phantom February 29th so every year is 366 days.
        if (d4 >= FEB_SKIP0) d4++;
        if (d4 >= FEB_SKIP1) d4++;
        if (d4 >= FEB_SKIP2) d4++;
        slot = d4 / 366;
        dy = d4 % 366;
        r.year = YEAR_W'(1970 + c400 * 400 + c4 * 4 + slot);
        m = 0;
        while (m < 11 && dy >= month_days[m]) begin
            dy -= month_days[m];
            m++;
        end
        r.month = MONTH_W'(m + 1);
        r.mday = MDAY_W'(dy + 1);
        return r;
    endfunction

    function automatic t_row dir_row(input longint unsigned secs, input logic [3:0] pad,
                                     input bit typed, input int y, input int mo,
                                     input int d, input int h, input int mi, input int s);
        t_row r;
        r.secs = SECS_W'(secs);
        r.pad = pad;
        r.typed = typed;
        r.want = '{year: YEAR_W'(y), month: MONTH_W'(mo), mday: MDAY_W'(d),
                   hour: HOUR_W'(h), minute: MIN_W'(mi), second: SEC_W'(s)};
        return r;
    endfunction

    task automatic send_request(input logic [SECS_W-1:0] secs, input logic [3:0] pad,
                                input t_utc want);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {pad, secs};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_dates.push_back(want);
        n_requests++;
        if (!quiet_tail && sender_gaps && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // Result checker: every result taken is matched against the oldest request.
    always @(posedge i_clk) begin : check_results
        t_utc want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            if (pending_dates.size() == 0) begin
                $error("result with no request outstanding: tdata %h", o_m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_dates.pop_front();
                compare_field("year", want.year, o_m_axis_tdata[0 +: YEAR_W]);
                compare_field("month", want.month, o_m_axis_tdata[YEAR_W +: MONTH_W]);
                compare_field("day_of_month", want.mday,
                              o_m_axis_tdata[YEAR_W+MONTH_W +: MDAY_W]);
                compare_field("hour", want.hour,
                              o_m_axis_tdata[YEAR_W+MONTH_W+MDAY_W +: HOUR_W]);
                compare_field("minute", want.minute,
                              o_m_axis_tdata[YEAR_W+MONTH_W+MDAY_W+HOUR_W +: MIN_W]);
                compare_field("second", want.second,
                              o_m_axis_tdata[YEAR_W+MONTH_W+MDAY_W+HOUR_W+MIN_W +: SEC_W]);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
            || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result side: random stalls, one long hold-off on request, none in the tail.
    initial begin : result_ready
        forever begin
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet_tail && receiver_gaps && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        t_row              rows [$];
        logic [SECS_W-1:0] secs;
        logic [3:0]        pad;
        logic [3:0]        hi;
        longint unsigned   sl;
        longint            days;
        int                mode;
        int                pick;
        int                four_year_marks [7];
        int                century_marks [3];

        four_year_marks = '{FEB_SKIP0 - 1, FEB_SKIP0, FEB_SKIP1 - 1, FEB_SKIP1,
                            FEB_SKIP2 - 1, FEB_SKIP2, 1460};
        century_marks = '{CENT_SKIP0, CENT_SKIP1, CENT_SKIP2};

        rows.push_back(dir_row(0, 4'h0, 1, 1970, 1, 1, 0, 0, 0));
        rows.push_back(dir_row(59, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(60, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(3599, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(86399, 4'h0, 1, 1970, 1, 1, 23, 59, 59));
        rows.push_back(dir_row(SEC_PER_DAY, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row((FEB_SKIP0 - 1) * SEC_PER_DAY, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(FEB_SKIP0 * SEC_PER_DAY, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row((FEB_SKIP1 - 1) * SEC_PER_DAY, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(FEB_SKIP1 * SEC_PER_DAY, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row((FEB_SKIP2 - 1) * SEC_PER_DAY, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(FEB_SKIP2 * SEC_PER_DAY, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(946684800, 4'h0, 1, 2000, 1, 1, 0, 0, 0));
        rows.push_back(dir_row(951782400, 4'h0, 1, 2000, 2, 29, 0, 0, 0));
        rows.push_back(dir_row(2147483647, 4'h0, 1, 2038, 1, 19, 3, 14, 7));
        // Last second before and first second of the day numbered by each century skip point.
        rows.push_back(dir_row(CENT_SKIP0 * SEC_PER_DAY - 1, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(CENT_SKIP0 * SEC_PER_DAY, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(CENT_SKIP1 * SEC_PER_DAY - 1, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(CENT_SKIP1 * SEC_PER_DAY, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(CENT_SKIP2 * SEC_PER_DAY - 1, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(CENT_SKIP2 * SEC_PER_DAY, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(146097 * SEC_PER_DAY - 1, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(146097 * SEC_PER_DAY, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_row(MAX_SECS, 4'h0, 0, 0, 0, 0, 0, 0, 0));
        // Padding bits above the timestamp must not change the result.
        rows.push_back(dir_row(MAX_SECS, 4'hF, 0, 0, 0, 0, 0, 0, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_request(rows[i].secs, rows[i].pad,
                         rows[i].typed ? rows[i].want : utc_of_seconds(rows[i].secs));
        end

        for (int i = 0; i < RANDOM_COUNT; i++) begin
            if (i % 100 == 0) begin
                sender_gaps = ($urandom_range(0, 2) != 0);
                receiver_gaps = ($urandom_range(0, 2) != 0);
            end
            if (i == RANDOM_COUNT - QUIET_TAIL) quiet_tail = 1'b1;
            if (i == 400) hold_req = 1'b1;
            if (i == 900) begin
                i_s_axis_tvalid <= 1'b0;
                while (pending_dates.size() != 0) @(posedge i_clk);
            end
            mode = $urandom_range(0, 9);
            if (mode <= 3) begin
                hi = 4'($urandom_range(0, 15));
                secs = {hi, $urandom()};
            end else if (mode <= 5) begin
                secs = SECS_W'($urandom());
            end else if (mode <= 8) begin
                // Around leap-day and century marks inside a random 400-year cycle.
                days = longint'($urandom_range(0, 5)) * 146097;
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    days += longint'($urandom_range(0, 99)) * 1461 + four_year_marks[pick];
                end else begin
                    days += century_marks[pick - 7];
                end
                days += longint'($urandom_range(0, 2)) - 1;
                if (days < 0) days = 0;
                sl = longint'(days) * SEC_PER_DAY + $urandom_range(0, 86399);
                secs = sl[SECS_W-1:0];
            end else begin
                sl = MAX_SECS - $urandom_range(0, 1 << 20);
                secs = sl[SECS_W-1:0];
            end
            pad = ($urandom_range(0, 31) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
            send_request(secs, pad, utc_of_seconds(secs));
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);

        $display("Converted %0d timestamps (%0d results checked) over the full 36-bit range,",
                 n_requests, n_results);
        $display("including leap-day, century and 400-year cycle edges and stalls on both sides.");
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
